FILE: rtl/bounded_multiset_table_defines.svh
// Assertion macros shared by the bounded multiset table modules
`ifndef BOUNDED_MULTISET_TABLE_DEFINES_SVH
`define BOUNDED_MULTISET_TABLE_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define BMS_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("bms assertion failed");

// next-cycle implication
`define BMS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("bms assertion failed");

`endif

FILE: rtl/bms_pkg.sv
// Types and constants shared by the bounded multiset table modules
package bms_pkg;

   localparam int ACTION_W = 3;
   localparam int ITEM_W   = 32;
   localparam int COUNT_W  = 5;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ADD      = 3'd0,
      ACT_REMOVE   = 3'd1,
      ACT_COUNT    = 3'd2,
      ACT_CONTAINS = 3'd3,
      ACT_LIST     = 3'd4,
      ACT_CLEAR    = 3'd5
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FIX,
      ST_LIST,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic push;
      logic clear;
      logic rd;
      logic cmp;
      logic fix;
      logic out_single;
      logic out_entry;
   } cmd_type;

   typedef struct packed {
      logic left_zero;
      logic rvalid;
      logic remove_hit;
      logic full;
      logic occ_zero;
      logic out_free;
   } sts_type;

endpackage

FILE: rtl/bms_ctrl.sv
// Sequencer for the bounded multiset table: accepts a word, walks the entries, issues results
module bms_ctrl
   import bms_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [ACTION_W-1:0] req_action,
   input  sts_type             sts,
   output cmd_type             cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               case (req_action)
                  ACT_ADD: begin
                     cmd.push = !sts.full;
                     state_in = ST_RESP;
                  end
                  ACT_REMOVE, ACT_COUNT, ACT_CONTAINS: begin
                     state_in = ST_SCAN;
                  end
                  ACT_LIST: begin
                     state_in = sts.occ_zero ? ST_RESP : ST_LIST;
                  end
                  ACT_CLEAR: begin
                     cmd.clear = 1'b1;
                     state_in  = ST_RESP;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            cmd.cmp = 1'b1;
            cmd.rd  = !sts.left_zero;
            if (sts.left_zero && !sts.rvalid) begin
               state_in = sts.remove_hit ? ST_FIX : ST_RESP;
            end
         end
         ST_FIX: begin
            cmd.fix  = 1'b1;
            state_in = ST_RESP;
         end
         ST_LIST: begin
            cmd.rd = (!sts.rvalid || sts.out_free) && !sts.left_zero;
            if (sts.rvalid && sts.out_free) begin
               cmd.out_entry = 1'b1;
               if (sts.left_zero) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_RESP: begin
            if (sts.out_free) begin
               cmd.out_single = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/bms_dp.sv
// Datapath of the bounded multiset table: entry memory, occupancy, compare and result register
`include "bounded_multiset_table_defines.svh"

module bms_dp
   import bms_pkg::*;
#(
   parameter int CAPACITY  = 16,
   parameter int ITEM_BITS = 32
)
(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output sts_type             sts,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [ITEM_W-1:0]   req_item,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_ok,
   output logic [COUNT_W-1:0]  rsp_frequency,
   output logic [COUNT_W-1:0]  rsp_size,
   output logic                rsp_empty_res,
   output logic [ITEM_W-1:0]   rsp_listed_item,
   output logic                rsp_item_valid,
   output logic                rsp_last
);

   localparam int OW = $clog2(CAPACITY + 1);
   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic [ITEM_BITS-1:0] mem [CAPACITY];

   logic [OW-1:0]        occ_ff, occ_in;
   logic [OW-1:0]        left_ff, left_in;
   logic [OW-1:0]        freq_ff, freq_in;
   logic [IW-1:0]        addr_ff, addr_in;
   logic [IW-1:0]        raddr_ff, raddr_in;
   logic [IW-1:0]        hit_ff, hit_in;
   logic                 rvalid_ff, rvalid_in;
   logic                 found_ff, found_in;
   logic                 add_ok_ff, add_ok_in;
   logic [ACTION_W-1:0]  action_ff, action_in;
   logic [ITEM_BITS-1:0] item_ff, item_in;
   logic [ITEM_BITS-1:0] head_ff, head_in;
   logic [ITEM_BITS-1:0] rdata_ff;

   logic                 out_valid_ff, out_valid_in;
   logic                 out_ok_ff, out_ok_in;
   logic [COUNT_W-1:0]   out_freq_ff, out_freq_in;
   logic [COUNT_W-1:0]   out_size_ff, out_size_in;
   logic                 out_empty_ff, out_empty_in;
   logic [ITEM_W-1:0]    out_item_ff, out_item_in;
   logic                 out_ivalid_ff, out_ivalid_in;
   logic                 out_last_ff, out_last_in;

   logic [OW-1:0]               occ_m1;
   logic [ITEM_BITS+ITEM_W-1:0] req_ext;
   logic [ITEM_BITS-1:0]        req_item_t;
   logic [ITEM_BITS+ITEM_W-1:0] rdata_ext;
   logic [OW+COUNT_W-1:0]       occ_ext;
   logic [OW+COUNT_W-1:0]       freq_ext;
   logic                        match;
   logic                        out_free;
   logic                        wr_en;
   logic [IW-1:0]               wr_addr;
   logic [ITEM_BITS-1:0]        wr_data;

   assign occ_m1     = occ_ff - 1'b1;
   assign req_ext    = {ITEM_BITS'(0), req_item};
   assign req_item_t = req_ext[ITEM_BITS-1:0];
   assign rdata_ext  = {ITEM_W'(0), rdata_ff};
   assign occ_ext    = {COUNT_W'(0), occ_ff};
   assign freq_ext   = {COUNT_W'(0), freq_ff};
   assign match      = rvalid_ff && (rdata_ff == item_ff);
   assign out_free   = !out_valid_ff || !rsp_stall;

   assign wr_en   = cmd.push || cmd.fix;
   assign wr_addr = cmd.fix ? hit_ff : occ_ff[IW-1:0];
   assign wr_data = cmd.fix ? head_ff : req_item_t;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd) begin
         rdata_ff <= mem[addr_ff];
      end
   end

   always_comb begin
      occ_in    = occ_ff;
      left_in   = left_ff;
      freq_in   = freq_ff;
      addr_in   = addr_ff;
      raddr_in  = raddr_ff;
      hit_in    = hit_ff;
      found_in  = found_ff;
      add_ok_in = add_ok_ff;
      action_in = action_ff;
      item_in   = item_ff;
      head_in   = head_ff;

      if (cmd.load) begin
         action_in = req_action;
         item_in   = req_item_t;
         left_in   = occ_ff;
         addr_in   = occ_m1[IW-1:0];
         freq_in   = '0;
         found_in  = 1'b0;
         add_ok_in = cmd.push;
      end
      if (cmd.push) begin
         occ_in = occ_ff + 1'b1;
      end
      if (cmd.clear) begin
         occ_in = '0;
      end
      if (cmd.fix) begin
         occ_in = occ_m1;
      end
      if (cmd.rd) begin
         raddr_in = addr_ff;
         addr_in  = addr_ff - 1'b1;
         left_in  = left_ff - 1'b1;
      end
      if (cmd.cmp) begin
         if (match) begin
            freq_in  = freq_ff + 1'b1;
            found_in = 1'b1;
            if (!found_ff) begin
               hit_in = raddr_ff;
            end
         end
         if (rvalid_ff && (raddr_ff == occ_m1[IW-1:0])) begin
            head_in = rdata_ff;
         end
      end

      if (cmd.rd) begin
         rvalid_in = 1'b1;
      end else if (cmd.cmp || cmd.out_entry) begin
         rvalid_in = 1'b0;
      end else begin
         rvalid_in = rvalid_ff;
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff && rsp_stall;
      out_ok_in     = out_ok_ff;
      out_freq_in   = out_freq_ff;
      out_size_in   = out_size_ff;
      out_empty_in  = out_empty_ff;
      out_item_in   = out_item_ff;
      out_ivalid_in = out_ivalid_ff;
      out_last_in   = out_last_ff;
      if (cmd.out_single || cmd.out_entry) begin
         out_valid_in = 1'b1;
         out_size_in  = occ_ext[COUNT_W-1:0];
         out_empty_in = (occ_ff == '0);
      end
      if (cmd.out_single) begin
         out_item_in   = '0;
         out_ivalid_in = 1'b0;
         out_last_in   = 1'b1;
         out_freq_in   = (action_ff == ACT_COUNT) ? freq_ext[COUNT_W-1:0] : '0;
         case (action_ff)
            ACT_ADD:      out_ok_in = add_ok_ff;
            ACT_REMOVE:   out_ok_in = found_ff;
            ACT_CONTAINS: out_ok_in = found_ff;
            default:      out_ok_in = 1'b0;
         endcase
      end
      if (cmd.out_entry) begin
         out_ok_in     = 1'b0;
         out_freq_in   = '0;
         out_item_in   = rdata_ext[ITEM_W-1:0];
         out_ivalid_in = 1'b1;
         out_last_in   = (left_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rvalid_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rvalid_ff    <= rvalid_in;
         out_valid_ff <= out_valid_in;
      end
      left_ff       <= left_in;
      freq_ff       <= freq_in;
      addr_ff       <= addr_in;
      raddr_ff      <= raddr_in;
      hit_ff        <= hit_in;
      found_ff      <= found_in;
      add_ok_ff     <= add_ok_in;
      action_ff     <= action_in;
      item_ff       <= item_in;
      head_ff       <= head_in;
      out_ok_ff     <= out_ok_in;
      out_freq_ff   <= out_freq_in;
      out_size_ff   <= out_size_in;
      out_empty_ff  <= out_empty_in;
      out_item_ff   <= out_item_in;
      out_ivalid_ff <= out_ivalid_in;
      out_last_ff   <= out_last_in;
   end

   assign sts.left_zero  = (left_ff == '0);
   assign sts.rvalid     = rvalid_ff;
   assign sts.remove_hit = found_ff && (action_ff == ACT_REMOVE);
   assign sts.full       = (occ_ff >= OW'(CAPACITY));
   assign sts.occ_zero   = (occ_ff == '0);
   assign sts.out_free   = out_free;

   assign rsp_valid       = out_valid_ff;
   assign rsp_ok          = out_ok_ff;
   assign rsp_frequency   = out_freq_ff;
   assign rsp_size        = out_size_ff;
   assign rsp_empty_res   = out_empty_ff;
   assign rsp_listed_item = out_item_ff;
   assign rsp_item_valid  = out_ivalid_ff;
   assign rsp_last        = out_last_ff;

   `BMS_ASSERT_NOW(a_occ_bound, 1'b1, occ_ff <= OW'(CAPACITY))
   `BMS_ASSERT_NOW(a_push_room, cmd.push, occ_ff < OW'(CAPACITY))
   `BMS_ASSERT_NOW(a_fix_hit, cmd.fix, found_ff && (occ_ff != '0))
   `BMS_ASSERT_NOW(a_entry_data, cmd.out_entry, rvalid_ff && out_free)
   `BMS_ASSERT_NEXT(a_fix_drop, cmd.fix, occ_ff == $past(occ_m1))

endmodule

FILE: rtl/bounded_multiset_table.sv
// Top level of the bounded multiset table: sequencer plus entry datapath
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  req_action, req_item
//  rsp      out        rsp_valid/rsp_stall  rsp_ok, rsp_frequency, rsp_size, rsp_empty_res,
//                                           rsp_listed_item, rsp_item_valid, rsp_last
//
// Add, clear, unused codes, list of an empty table: after the accept, the result is registered
// once the result register is free, and the sequencer then returns to idle for the next word.
// Count, contains, remove: a scan over all occupied entries, plus a fix step on a remove hit;
// one entry read per cycle from the read port of the entry memory. List: one word per cycle
// while rsp_stall is low. Synchronous reset empties the table; entry memory is not cleared.
// The result register lets the next request proceed while a result waits under rsp_stall.
module bounded_multiset_table
   import bms_pkg::*;
#(
   parameter int CAPACITY  = 16,
   parameter int ITEM_BITS = 32
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [ITEM_W-1:0]   req_item,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_ok,
   output logic [COUNT_W-1:0]  rsp_frequency,
   output logic [COUNT_W-1:0]  rsp_size,
   output logic                rsp_empty_res,
   output logic [ITEM_W-1:0]   rsp_listed_item,
   output logic                rsp_item_valid,
   output logic                rsp_last
);

   cmd_type cmd;
   sts_type sts;

   bms_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (req_action),
      .sts        (sts),
      .cmd        (cmd)
   );

   bms_dp #(
      .CAPACITY  (CAPACITY),
      .ITEM_BITS (ITEM_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_action      (req_action),
      .req_item        (req_item),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_ok          (rsp_ok),
      .rsp_frequency   (rsp_frequency),
      .rsp_size        (rsp_size),
      .rsp_empty_res   (rsp_empty_res),
      .rsp_listed_item (rsp_listed_item),
      .rsp_item_valid  (rsp_item_valid),
      .rsp_last        (rsp_last)
   );

endmodule

FILE: test/bounded_multiset_table_tb.sv
// Self-checking testbench for the bounded multiset table: random and directed bag traffic
`timescale 1ns / 1ps
module bounded_multiset_table_tb;
   import bms_pkg::*;

   localparam int CAPACITY    = 16;
   localparam int ITEM_COUNT  = 460;
   localparam int QUIET_LIMIT = 4000;
   localparam int TAIL_CYCLES = 40;
   localparam int PRINT_CAP   = 40;
   localparam int POOL_SIZE   = 5;
   localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd7;

   typedef struct {
      logic [ACTION_W-1:0] action;
      logic [ITEM_W-1:0]   item;
      bit                  drain;
      int                  phase;
   } req_word_type;

   typedef struct packed {
      logic               ok;
      logic [COUNT_W-1:0] freq;
      logic [COUNT_W-1:0] size;
      logic               empty;
      logic [ITEM_W-1:0]  listed;
      logic               listed_valid;
      logic               last;
   } bag_reply_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_valid  = 1'b0;
   logic [ACTION_W-1:0] req_action = ACT_ADD;
   logic [ITEM_W-1:0]   req_item   = '0;
   logic                rsp_stall  = 1'b0;
   logic                req_stall;
   logic                rsp_valid;
   logic                rsp_ok;
   logic [COUNT_W-1:0]  rsp_frequency;
   logic [COUNT_W-1:0]  rsp_size;
   logic                rsp_empty_res;
   logic [ITEM_W-1:0]   rsp_listed_item;
   logic                rsp_item_valid;
   logic                rsp_last;

   req_word_type      pending_words[$];
   bag_reply_type     replies_due[$];
   logic [ITEM_W-1:0] bag_slot[CAPACITY];
   int                bag_size = 0;
   logic [ITEM_W-1:0] val_pool[POOL_SIZE];
   int                phase = 0;
   int                errors = 0;
   int                reply_words = 0;
   int                full_refusals = 0;
   int                remove_hits = 0;
   int                action_tally[8];
   int                random_words = 0;
   int                quiet_cycles = 0;

   bounded_multiset_table dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ok         (rsp_ok),
      .rsp_frequency  (rsp_frequency),
      .rsp_size       (rsp_size),
      .rsp_empty_res  (rsp_empty_res),
      .rsp_listed_item(rsp_listed_item),
      .rsp_item_valid (rsp_item_valid),
      .rsp_last       (rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int sender_idle(input int ph);
      case (ph)
         0:       return 16;
         1:       return 71;
         default: return 0;
      endcase
   endfunction

   function automatic int receiver_idle(input int ph);
      case (ph)
         0:       return 71;
         1:       return 16;
         default: return 0;
      endcase
   endfunction

   function automatic logic [ITEM_W-1:0] pick_item();
      if ($urandom_range(3) == 0) return $urandom;
      return val_pool[$urandom_range(POOL_SIZE - 1)];
   endfunction

   task automatic refresh_pool();
      int j;
      for (j = 0; j < POOL_SIZE; j++) begin
         case ($urandom_range(7))
            0:       val_pool[j] = '0;
            1:       val_pool[j] = '1;
            default: val_pool[j] = $urandom;
         endcase
      end
   endtask

   task automatic queue_word(input logic [ACTION_W-1:0] act, input logic [ITEM_W-1:0] val);
      req_word_type w;
      w.action = act;
      w.item   = val;
      w.drain  = 1'b0;
      w.phase  = 0;
      pending_words = {pending_words, w};
      random_words++;
   endtask

   task automatic queue_mixed_op();
      int r;
      r = $urandom_range(99);
      if (r < 35)      queue_word(ACT_ADD, pick_item());
      else if (r < 55) queue_word(ACT_REMOVE, pick_item());
      else if (r < 67) queue_word(ACT_COUNT, pick_item());
      else if (r < 79) queue_word(ACT_CONTAINS, pick_item());
      else if (r < 86) queue_word(ACT_LIST, pick_item());
      else if (r < 90) queue_word(ACT_CLEAR, pick_item());
      else if (r < 95) queue_word($urandom_range(1) ? ACT_SPARE_A : ACT_SPARE_B, $urandom);
      else             queue_word(ACTION_W'($urandom_range(7)), $urandom);
   endtask

   // bag model: slot bag_size-1 is the head
   task automatic apply_to_bag(input logic [ACTION_W-1:0] act, input logic [ITEM_W-1:0] val);
      bag_reply_type r;
      int            i;
      int            n;
      int            hits;
      logic          found;
      n     = bag_size;
      hits  = 0;
      found = 1'b0;
      r     = '0;
      r.last = 1'b1;
      action_tally[act]++;
      case (act)
         ACT_ADD: begin
            if (n < CAPACITY) begin
               bag_slot[n] = val;
               bag_size    = n + 1;
               r.ok        = 1'b1;
            end else begin
               full_refusals++;
            end
         end
         ACT_REMOVE: begin
            for (i = n - 1; i >= 0 && !found; i--) begin
               if (bag_slot[i] == val) begin
                  bag_slot[i] = bag_slot[n - 1];
                  bag_size    = n - 1;
                  found       = 1'b1;
               end
            end
            r.ok = found;
            if (found) remove_hits++;
         end
         ACT_COUNT: begin
            for (i = 0; i < n; i++) if (bag_slot[i] == val) hits++;
            r.freq = hits[COUNT_W-1:0];
         end
         ACT_CONTAINS: begin
            for (i = 0; i < n; i++) if (bag_slot[i] == val) found = 1'b1;
            r.ok = found;
         end
         ACT_CLEAR: bag_size = 0;
         default: ;
      endcase
      r.size  = bag_size[COUNT_W-1:0];
      r.empty = (bag_size == 0);
      if (act == ACT_LIST && bag_size > 0) begin
         for (i = bag_size - 1; i >= 0; i--) begin
            r.listed       = bag_slot[i];
            r.listed_valid = 1'b1;
            r.last         = (i == 0);
            replies_due    = {replies_due, r};
         end
      end else begin
         replies_due = {replies_due, r};
      end
   endtask

   task automatic flag_mismatch(input string what, input logic [ITEM_W-1:0] got,
                                input logic [ITEM_W-1:0] want);
      errors++;
      if (errors <= PRINT_CAP)
         $display("mismatch at reply word %0d: %s got %h want %h", reply_words, what, got, want);
   endtask

   task automatic check_field(input string what, input logic [ITEM_W-1:0] got,
                              input logic [ITEM_W-1:0] want);
      if (got !== want) flag_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin : req_side
      req_word_type w;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) apply_to_bag(req_action, req_item);
         if (!(req_valid && req_stall)) begin
            if (pending_words.size() > 0
                && !(pending_words[0].drain && replies_due.size() > 0)
                && $urandom_range(99) >= sender_idle(phase)) begin
               w = pending_words.pop_front();
               req_valid  <= 1'b1;
               req_action <= w.action;
               req_item   <= w.item;
               phase      <= w.phase;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_side
      bag_reply_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle(phase));
         if (rsp_valid && !rsp_stall) begin
            reply_words++;
            if (replies_due.size() == 0) begin
               flag_mismatch("reply word with nothing due, listed_item", rsp_listed_item, '0);
            end else begin
               want = replies_due.pop_front();
               check_field("ok", rsp_ok, want.ok);
               check_field("frequency", rsp_frequency, want.freq);
               check_field("size", rsp_size, want.size);
               check_field("empty_res", rsp_empty_res, want.empty);
               check_field("listed_item", rsp_listed_item, want.listed);
               check_field("item_valid", rsp_item_valid, want.listed_valid);
               check_field("last", rsp_last, want.last);
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   initial begin : stimulus
      req_word_type w;
      int           total;
      int           k;
      int           prev_phase;

      // directed: empty bag, duplicates, extremes, miss, spare codes, clear
      queue_word(ACT_LIST, '0);
      queue_word(ACT_REMOVE, '0);
      queue_word(ACT_COUNT, '0);
      queue_word(ACT_CONTAINS, '1);
      queue_word(ACT_ADD, '0);
      queue_word(ACT_ADD, '1);
      queue_word(ACT_ADD, 32'hA5A5_A5A5);
      queue_word(ACT_ADD, '0);
      queue_word(ACT_COUNT, '0);
      queue_word(ACT_CONTAINS, '1);
      queue_word(ACT_CONTAINS, 32'h5A5A_5A5A);
      queue_word(ACT_LIST, '0);
      queue_word(ACT_REMOVE, '1);
      queue_word(ACT_REMOVE, 32'h1234_5678);
      queue_word(ACT_LIST, '1);
      queue_word(ACT_SPARE_A, 32'hFFFF_0000);
      queue_word(ACT_SPARE_B, 32'h0000_FFFF);
      queue_word(ACT_CLEAR, '0);
      queue_word(ACT_LIST, '0);
      queue_word(ACT_COUNT, '1);

      while (random_words < ITEM_COUNT) begin
         refresh_pool();
         if ($urandom_range(2) == 0) begin
            // fill toward full, then probe, list and sometimes clear
            repeat ($urandom_range(12, 20)) queue_word(ACT_ADD, pick_item());
            repeat ($urandom_range(2, 6)) queue_mixed_op();
            queue_word(ACT_LIST, pick_item());
            if ($urandom_range(1)) queue_word(ACT_CLEAR, pick_item());
         end else begin
            repeat ($urandom_range(8, 20)) queue_mixed_op();
         end
      end

      total      = pending_words.size();
      prev_phase = 0;
      for (k = 0; k < total; k++) begin
         w       = pending_words[k];
         w.phase = k * 3 / total;
         w.drain = (w.phase != prev_phase) || ($urandom_range(49) == 0);
         prev_phase = w.phase;
         pending_words[k] = w;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (pending_words.size() > 0 || req_valid || replies_due.size() > 0);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("covered %0d request words: add %0d remove %0d count %0d contains %0d list %0d",
               total, action_tally[ACT_ADD], action_tally[ACT_REMOVE], action_tally[ACT_COUNT],
               action_tally[ACT_CONTAINS], action_tally[ACT_LIST]);
      $display("clear %0d, spare codes %0d, %0d reply words, %0d remove hits, %0d full refusals",
               action_tally[ACT_CLEAR], action_tally[ACT_SPARE_A] + action_tally[ACT_SPARE_B],
               reply_words, remove_hits, full_refusals);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", errors);
         $display("status: fail");
      end
      $finish;
   end

endmodule
